>>> hdl/kdlr_pkg.sv
// kdlr_pkg: shared types and constants for the keypad debounce / long-press / repeat unit.
// No dependencies.
package kdlr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int KEY_W    = 5;
  localparam int PERIOD_W = 16;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd1;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRESS   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LONG    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REPEAT  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd5;

  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST   = 16'd100;
  localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 16'd20;

  typedef struct packed {
    logic             released;
    logic             repeated;
    logic             long_press;
    logic             pressed;
  } key_flags_t;

  typedef struct packed {
    key_flags_t       flags;
    logic [KEY_W-1:0] key_code;
  } key_result_t;

endpackage

>>> hdl/keypad_debounce_long_repeat_unit.sv
// keypad_debounce_long_repeat_unit: top level - config registers, input and output
// register stages around kdlr_fsm. Depends on kdlr_pkg and kdlr_fsm.
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | [15:0] matrix_sample           | -
//  out_    | out | [4:0] key_code, [7:5] zero     | [0] pressed [1] long [2] repeat [3] released
//  cfg_    | in  | wr_en / index / [15:0] wdata   | -
//
// One word per cycle sustained while out_ is not stalled; an accepted word passes through the
// input register, then the result register, before it is presented on out_. Reset is
// synchronous on rst_n and restores the periods to 100 and 20. A stalled output holds its
// word; the input stage keeps taking words until both registers are full.
module keypad_debounce_long_repeat_unit #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] matrix_sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [4:0] key_code, [7:5] zero
  output logic [3:0]                      out_tuser,  // pressed, long, repeat, released
  input  logic                            cfg_wr_en,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdlr_pkg::PERIOD_W-1:0]   cfg_wdata
);
  import kdlr_pkg::*;

  logic [PERIOD_W-1:0] long_period_r, repeat_period_r;
  logic                in_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                out_valid_r;
  key_result_t         out_r, res;
  logic                out_free, fire;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_period_r   <= LONG_PERIOD_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LONG_PERIOD:   long_period_r   <= cfg_wdata;
        REG_REPEAT_PERIOD: repeat_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r <= in_tdata;
    end
  end

  kdlr_fsm #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .sample        (sample_r),
    .long_period   (long_period_r),
    .repeat_period (repeat_period_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.key_code};
  assign out_tuser  = out_r.flags;

endmodule

>>> hdl/kdlr_fsm.sv
// kdlr_fsm: matrix priority encoder, phase machine and saturating hold counter.
// Produces one result per processed word. Depends on kdlr_pkg.
module kdlr_fsm #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [kdlr_pkg::SAMPLE_W-1:0]  sample,
  input  logic [kdlr_pkg::PERIOD_W-1:0]  long_period,
  input  logic [kdlr_pkg::PERIOD_W-1:0]  repeat_period,
  output kdlr_pkg::key_result_t          res
);
  import kdlr_pkg::*;

  // compare width covers both the counter and the 16-bit periods
  localparam int CMP_W = (COUNTER_WIDTH > PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic [COUNTER_WIDTH-1:0] hold_r, hold_nxt, hold_inc;
  logic [KEY_W-1:0]         latched_r, latched_nxt;
  logic [KEY_W-1:0]         code;
  logic                     exceeds_long, exceeds_repeat;

  // lowest set bit wins; bit row*4+col gives col*4+row+1
  always_comb begin
    code = '0;
    for (int i = SAMPLE_W - 1; i >= 0; i--) begin
      if (sample[i]) begin
        code = {1'b0, 2'(i), 2'(i >> 2)} + KEY_W'(1);
      end
    end
  end

  assign hold_inc       = (hold_r == CNT_MAX) ? hold_r : hold_r + COUNTER_WIDTH'(1);
  assign exceeds_long   = CMP_W'(hold_inc) > CMP_W'(long_period);
  assign exceeds_repeat = CMP_W'(hold_inc) > CMP_W'(repeat_period);

  always_comb begin
    phase_nxt    = phase_r;
    hold_nxt     = hold_r;
    latched_nxt  = latched_r;
    res          = '0;
    res.key_code = code;
    case (phase_r)
      PH_IDLE: begin
        if (code != '0) phase_nxt = PH_SETTLE;
      end
      PH_SETTLE: begin
        phase_nxt = PH_PRESS;
      end
      PH_PRESS: begin
        if (code != '0) begin
          latched_nxt       = code;
          hold_nxt          = '0;
          res.flags.pressed = 1'b1;
          phase_nxt         = PH_LONG;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (code != '0) begin
          hold_nxt = hold_inc;
          if (exceeds_long) begin
            hold_nxt             = '0;
            res.flags.long_press = 1'b1;
            phase_nxt            = PH_REPEAT;
          end
        end else begin
          phase_nxt = PH_RELEASE;
        end
      end
      PH_REPEAT: begin
        if (code != '0) begin
          hold_nxt = hold_inc;
          if (exceeds_repeat) begin
            hold_nxt           = '0;
            res.flags.repeated = 1'b1;
          end
        end else begin
          phase_nxt = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        res.key_code       = latched_r;
        res.flags.released = 1'b1;
        phase_nxt          = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hold_r    <= '0;
      latched_r <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      hold_r    <= hold_nxt;
      latched_r <= latched_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> $countones(res.flags) <= 1)
    else $error("more than one event flag on a word");

  a_press_to_long: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.flags.pressed |=> phase_r == PH_LONG && hold_r == '0)
    else $error("press not followed by long phase with cleared count");

  a_long_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.flags.long_press |=> phase_r == PH_REPEAT && hold_r == '0)
    else $error("long flag not followed by repeat phase with cleared count");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_RELEASE)
    else $error("phase outside decoded range");
`endif

endmodule
